### sv/bpa_pkg.sv
// Shared definitions of the buddy page allocator: operation, status and
// descriptor codes plus default sizing. No dependencies.
package bpa_pkg;

  // Default sizing, handed to the top level parameters
  localparam int unsigned NumOrdersDef      = 11;
  localparam int unsigned PageBytesDef      = 4096;
  localparam int unsigned MaxBlocksDef      = 256;
  localparam int unsigned PageNumberBitsDef = 20;

  // Order fields are fixed at four bits (up to sixteen orders)
  localparam int unsigned ORDER_W = 4;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_ALLOC  = 2'd1,
    MODE_FREE   = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOMEM    = 2'd1,
    ST_INVAL    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    K_UNUSED = 2'd0,
    K_FREE   = 2'd1,
    K_ALLOC  = 2'd2,
    K_SPLIT  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    P_TOP   = 2'd0,
    P_LEFT  = 2'd1,
    P_RIGHT = 2'd2
  } pos_e;

endpackage

### sv/bpa_ram.sv
// Simple dual-port synchronous RAM with bit write mask and registered read.
// Used for the block table and the free-list links. No dependencies.
module bpa_ram #(
  parameter int unsigned DW    = 8,
  parameter int unsigned AW    = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [DW-1:0] wmask_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  // masked write, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= (mem[waddr_i] & ~wmask_i) | (wdata_i & wmask_i);
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### sv/bpa_desc_pool.sv
// Descriptor pool: availability bits, free count and a two-step lowest-index
// search (group of sixteen, then bit). Depends on bpa_pkg.
module bpa_desc_pool import bpa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MaxBlocksDef,
  localparam int unsigned IW = $clog2(MAX_BLOCKS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          grp_latch_i,
  input  logic          take_i,
  input  logic          rel_vld_i,
  input  logic [IW-1:0] rel_a_i,
  input  logic [IW-1:0] rel_b_i,
  input  logic [IW-1:0] query_idx_i,
  output logic          query_avail_o,
  output logic [IW-1:0] take_idx_o,
  output logic [IW:0]   avail_cnt_o
);

  localparam int unsigned GS = 16;
  localparam int unsigned NG = MAX_BLOCKS / GS;
  localparam int unsigned GW = (NG > 1) ? $clog2(NG) : 1;

  logic [MAX_BLOCKS-1:0] pool_q;
  logic [GW-1:0]         grp_q, grp_sel;
  logic [IW:0]           cnt_q;
  logic [GS-1:0]         grp_bits;
  logic [3:0]            bit_sel;

  // lowest group holding a free descriptor
  always_comb begin
    grp_sel = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (|pool_q[g*GS +: GS]) grp_sel = GW'(g);
    end
  end

  // lowest free bit inside the latched group
  always_comb begin
    grp_bits = pool_q[{grp_q, 4'b0000} +: GS];
    bit_sel  = '0;
    for (int b = GS - 1; b >= 0; b--) begin
      if (grp_bits[b]) bit_sel = 4'(b);
    end
  end

  assign take_idx_o    = IW'({grp_q, bit_sel});
  assign query_avail_o = pool_q[query_idx_i];
  assign avail_cnt_o   = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= '1;
      grp_q  <= '0;
      cnt_q  <= (IW+1)'(MAX_BLOCKS);
    end else begin
      if (grp_latch_i) grp_q <= grp_sel;
      if (take_i) begin
        pool_q[take_idx_o] <= 1'b0;
        cnt_q              <= cnt_q - 1'b1;
      end else if (rel_vld_i) begin
        pool_q[rel_a_i] <= 1'b1;
        pool_q[rel_b_i] <= 1'b1;
        cnt_q           <= cnt_q + 2'd2;
      end
    end
  end

endmodule

### sv/buddy_page_allocator_unit.sv
// Buddy page allocator: one result per request, one request at a time.
// Insert adds one top block per set bit; allocate splits one level at a time;
// free and lookup scan the block table one descriptor a cycle, then free
// merges one level at a time, walking the block table and link memories.
// Reset: asynchronous, all free lists empty and all descriptors available.
module buddy_page_allocator_unit import bpa_pkg::*; #(
  parameter int unsigned NUM_ORDERS       = NumOrdersDef,
  parameter int unsigned PAGE_BYTES       = PageBytesDef,
  parameter int unsigned MAX_BLOCKS       = MaxBlocksDef,
  parameter int unsigned PAGE_NUMBER_BITS = PageNumberBitsDef,
  localparam int unsigned PNB   = PAGE_NUMBER_BITS,
  localparam int unsigned IN_W  = ((PNB + 32 + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((PNB + ORDER_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // page_number, size_bytes, zero pad
  input  logic [1:0]       s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // result_page, result_order, zero pad
  output logic [1:0]       m_axis_tuser   // status
);

  localparam int unsigned IW  = $clog2(MAX_BLOCKS);
  localparam int unsigned OIW = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
  localparam int unsigned PSH = $clog2(PAGE_BYTES);
  localparam int unsigned OW  = ORDER_W;

  typedef struct packed {
    logic [PNB-1:0] page;
    logic [OW-1:0]  order;
    kind_e          kind;
    pos_e           pos;
    logic [IW-1:0]  buddy;
    logic [IW-1:0]  parent;
  } blk_t;

  typedef struct packed {
    logic [IW-1:0] nxt;
    logic [IW-1:0] prv;
  } lnk_t;

  localparam int unsigned BW = $bits(blk_t);
  localparam int unsigned LW = $bits(lnk_t);

  typedef enum logic [23:0] {
    S_IDLE     = 24'h000001,
    S_DEC      = 24'h000002,
    S_INS_BIT  = 24'h000004,
    S_INS_WR   = 24'h000008,
    S_ALC_LD   = 24'h000010,
    S_ALC_LOOP = 24'h000020,
    S_ALC_L    = 24'h000040,
    S_ALC_R    = 24'h000080,
    S_ALC_F    = 24'h000100,
    S_FIND     = 24'h000200,
    S_PB_CHK   = 24'h000400,
    S_PB_BD    = 24'h000800,
    S_PB_REL   = 24'h001000,
    S_PB_PL    = 24'h002000,
    S_PB_FIN   = 24'h004000,
    S_PUSH0    = 24'h008000,
    S_PUSH1    = 24'h010000,
    S_RM0      = 24'h020000,
    S_RM1      = 24'h040000,
    S_RM2      = 24'h080000,
    S_TK0      = 24'h100000,
    S_TK1      = 24'h200000,
    S_DONE     = 24'h400000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  // request and walk registers
  mode_e                 mode_q, mode_d;
  logic [PNB-1:0]        pn_q, pn_d;
  logic [31:0]           sz_q, sz_d;
  logic [NUM_ORDERS-1:0] pages_q, pages_d;
  logic [OW:0]           bit_q, bit_d;
  logic [OW-1:0]         ord_q, ord_d, src_q, src_d;
  blk_t                  cur_q, cur_d;
  logic [IW-1:0]         cur_idx_q, cur_idx_d, l_idx_q, l_idx_d, tk_q, tk_d;
  logic [IW-1:0]         sub_idx_q, sub_idx_d, chk_idx_q, chk_idx_d;
  logic [OW-1:0]         sub_ord_q, sub_ord_d;
  lnk_t                  lk_q, lk_d;
  logic [IW:0]           scan_q, scan_d;
  logic                  chk_vld_q, chk_vld_d;
  status_e               st_q, st_d;
  logic [PNB-1:0]        rp_q, rp_d;
  logic [OW-1:0]         ro_q, ro_d;

  // free-list heads, tails and non-empty flags per order
  logic [IW-1:0] head_q [NUM_ORDERS];
  logic [IW-1:0] head_d [NUM_ORDERS];
  logic [IW-1:0] tail_q [NUM_ORDERS];
  logic [IW-1:0] tail_d [NUM_ORDERS];
  logic [NUM_ORDERS-1:0] ne_q, ne_d;

  // output register
  logic           out_vld_q;
  status_e        out_st_q;
  logic [PNB-1:0] out_page_q;
  logic [OW-1:0]  out_ord_q;
  logic           out_load;

  // memory ports
  logic          b_we;
  logic [IW-1:0] b_waddr, b_raddr;
  blk_t          b_wdata, b_rd;
  logic [BW-1:0] b_rdata;
  logic          l_we;
  logic [IW-1:0] l_waddr, l_raddr;
  lnk_t          l_wdata, l_wmask, l_rd;
  logic [LW-1:0] l_rdata;

  // descriptor pool ports
  logic          grp_latch, take, rel_vld, q_avail;
  logic [IW-1:0] rel_a, rel_b, q_idx, take_idx;
  logic [IW:0]   avail;

  // decode helpers
  logic [31:0]     ins_full;
  logic [NUM_ORDERS-1:0] ins_pages;
  logic [4:0]      need;
  logic [32:0]     alc_pages;
  logic [OW-1:0]   ord_v, src_v;
  logic            ord_ok, src_ok;
  logic [IW:0]     split_need;
  logic [OIW-1:0]  so;
  logic            hit;

  assign b_rd = blk_t'(b_rdata);
  assign l_rd = lnk_t'(l_rdata);

  bpa_ram #(.DW(BW), .AW(IW), .DEPTH(MAX_BLOCKS)) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .wmask_i ({BW{1'b1}}),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  bpa_ram #(.DW(LW), .AW(IW), .DEPTH(MAX_BLOCKS)) u_lnk_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .wmask_i (l_wmask),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  bpa_desc_pool #(.MAX_BLOCKS(MAX_BLOCKS)) u_pool (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .grp_latch_i   (grp_latch),
    .take_i        (take),
    .rel_vld_i     (rel_vld),
    .rel_a_i       (rel_a),
    .rel_b_i       (rel_b),
    .query_idx_i   (q_idx),
    .query_avail_o (q_avail),
    .take_idx_o    (take_idx),
    .avail_cnt_o   (avail)
  );

  // request decode: page counts, orders, descriptor needs
  always_comb begin
    ins_full  = sz_q >> PSH;
    ins_pages = ins_full[NUM_ORDERS-1:0];
    need      = '0;
    for (int i = 0; i < NUM_ORDERS; i++) begin
      need = need + 5'(ins_pages[i]);
    end
    alc_pages = (33'(sz_q) + 33'(PAGE_BYTES - 1)) >> PSH;
    ord_v  = '0;
    ord_ok = 1'b0;
    for (int i = NUM_ORDERS - 1; i >= 0; i--) begin
      if (alc_pages <= (33'(1) << i)) begin
        ord_v  = OW'(i);
        ord_ok = 1'b1;
      end
    end
    src_v  = '0;
    src_ok = 1'b0;
    for (int j = NUM_ORDERS - 1; j >= 0; j--) begin
      if (ne_q[j] && (OW'(j) >= ord_v)) begin
        src_v  = OW'(j);
        src_ok = 1'b1;
      end
    end
    split_need = (IW+1)'({src_v - ord_v, 1'b0});
  end

  assign so  = sub_ord_q[OIW-1:0];
  assign hit = chk_vld_q && !q_avail && (b_rd.kind == K_ALLOC) && (b_rd.page == pn_q);

  // sequencer
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    mode_d    = mode_q;
    pn_d      = pn_q;
    sz_d      = sz_q;
    pages_d   = pages_q;
    bit_d     = bit_q;
    ord_d     = ord_q;
    src_d     = src_q;
    cur_d     = cur_q;
    cur_idx_d = cur_idx_q;
    l_idx_d   = l_idx_q;
    tk_d      = tk_q;
    sub_idx_d = sub_idx_q;
    sub_ord_d = sub_ord_q;
    chk_idx_d = chk_idx_q;
    lk_d      = lk_q;
    scan_d    = scan_q;
    chk_vld_d = chk_vld_q;
    st_d      = st_q;
    rp_d      = rp_q;
    ro_d      = ro_q;
    head_d    = head_q;
    tail_d    = tail_q;
    ne_d      = ne_q;
    b_we      = 1'b0;
    b_waddr   = cur_idx_q;
    b_wdata   = cur_q;
    b_raddr   = cur_q.buddy;
    l_we      = 1'b0;
    l_waddr   = sub_idx_q;
    l_wdata   = '{nxt: sub_idx_q, prv: sub_idx_q};
    l_wmask   = '1;
    l_raddr   = sub_idx_q;
    grp_latch = 1'b0;
    take      = 1'b0;
    rel_vld   = 1'b0;
    rel_a     = cur_q.buddy;
    rel_b     = cur_idx_q;
    q_idx     = cur_q.buddy;
    out_load  = 1'b0;
    s_axis_tready = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d  = mode_e'(s_axis_tuser);
          pn_d    = s_axis_tdata[PNB-1:0];
          sz_d    = s_axis_tdata[PNB +: 32];
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        st_d = ST_OK;
        rp_d = '0;
        ro_d = '0;
        case (mode_q)
          MODE_INSERT: begin
            if (ins_full == 32'd0) begin
              st_d    = ST_INVAL;
              state_d = S_DONE;
            end else if ((IW+1)'(need) > avail) begin
              st_d    = ST_NOMEM;
              state_d = S_DONE;
            end else begin
              pages_d = ins_pages;
              bit_d   = '0;
              state_d = S_INS_BIT;
            end
          end
          MODE_ALLOC: begin
            if (sz_q == 32'd0) begin
              st_d    = ST_INVAL;
              state_d = S_DONE;
            end else if (!ord_ok || !src_ok || (split_need > avail)) begin
              st_d    = ST_NOMEM;
              state_d = S_DONE;
            end else begin
              ord_d     = ord_v;
              src_d     = src_v;
              cur_idx_d = head_q[src_v[OIW-1:0]];
              b_raddr   = head_q[src_v[OIW-1:0]];
              state_d   = S_ALC_LD;
            end
          end
          default: begin
            scan_d    = '0;
            chk_vld_d = 1'b0;
            state_d   = S_FIND;
          end
        endcase
      end

      // insert: one top block per set bit of the page count
      S_INS_BIT: begin
        if (bit_q == (OW+1)'(NUM_ORDERS)) begin
          state_d = S_DONE;
        end else if (pages_q[bit_q[OIW-1:0]]) begin
          ret_d   = S_INS_WR;
          state_d = S_TK0;
        end else begin
          bit_d = bit_q + 1'b1;
        end
      end

      S_INS_WR: begin
        b_we      = 1'b1;
        b_waddr   = tk_q;
        b_wdata   = '{page: pn_q, order: bit_q[OW-1:0], kind: K_FREE, pos: P_TOP,
                      buddy: '0, parent: '0};
        sub_idx_d = tk_q;
        sub_ord_d = bit_q[OW-1:0];
        pn_d      = pn_q + (PNB'(1) << bit_q);
        bit_d     = bit_q + 1'b1;
        ret_d     = S_INS_BIT;
        state_d   = S_PUSH0;
      end

      // allocate: pop source head, then split down to the wanted order
      S_ALC_LD: begin
        cur_d     = b_rd;
        sub_idx_d = cur_idx_q;
        sub_ord_d = src_q;
        ret_d     = S_ALC_LOOP;
        state_d   = S_RM0;
      end

      S_ALC_LOOP: begin
        if (src_q == ord_q) begin
          b_we         = 1'b1;
          b_wdata      = cur_q;
          b_wdata.kind = K_ALLOC;
          rp_d         = cur_q.page;
          ro_d         = cur_q.order;
          state_d      = S_DONE;
        end else begin
          ret_d   = S_ALC_L;
          state_d = S_TK0;
        end
      end

      S_ALC_L: begin
        l_idx_d = tk_q;
        ret_d   = S_ALC_R;
        state_d = S_TK0;
      end

      S_ALC_R: begin
        b_we      = 1'b1;
        b_waddr   = tk_q;
        b_wdata   = '{page: cur_q.page + (PNB'(1) << (src_q - 1'b1)),
                      order: src_q - 1'b1, kind: K_FREE, pos: P_RIGHT,
                      buddy: l_idx_q, parent: cur_idx_q};
        sub_idx_d = tk_q;
        sub_ord_d = src_q - 1'b1;
        ret_d     = S_ALC_F;
        state_d   = S_PUSH0;
      end

      S_ALC_F: begin
        b_we         = 1'b1;
        b_wdata      = cur_q;
        b_wdata.kind = K_SPLIT;
        cur_d        = '{page: cur_q.page, order: src_q - 1'b1, kind: K_ALLOC,
                         pos: P_LEFT, buddy: sub_idx_q, parent: cur_idx_q};
        cur_idx_d    = l_idx_q;
        src_d        = src_q - 1'b1;
        state_d      = S_ALC_LOOP;
      end

      // free / lookup: pipelined scan of the block table
      S_FIND: begin
        b_raddr = scan_q[IW-1:0];
        q_idx   = chk_idx_q;
        if (hit) begin
          rp_d = b_rd.page;
          ro_d = b_rd.order;
          if (mode_q == MODE_LOOKUP) begin
            state_d = S_DONE;
          end else begin
            cur_d     = b_rd;
            cur_idx_d = chk_idx_q;
            state_d   = S_PB_CHK;
          end
        end else if (!chk_vld_q && (scan_q == (IW+1)'(MAX_BLOCKS))) begin
          st_d    = ST_NOTFOUND;
          state_d = S_DONE;
        end else begin
          chk_vld_d = (scan_q != (IW+1)'(MAX_BLOCKS));
          chk_idx_d = scan_q[IW-1:0];
          if (scan_q != (IW+1)'(MAX_BLOCKS)) scan_d = scan_q + 1'b1;
        end
      end

      // merge loop
      S_PB_CHK: begin
        if (cur_q.pos == P_TOP) begin
          state_d = S_PB_FIN;
        end else begin
          b_raddr = cur_q.buddy;
          state_d = S_PB_BD;
        end
      end

      S_PB_BD: begin
        if (q_avail || (b_rd.kind != K_FREE)) begin
          state_d = S_PB_FIN;
        end else begin
          sub_idx_d = cur_q.buddy;
          sub_ord_d = b_rd.order;
          ret_d     = S_PB_REL;
          state_d   = S_RM0;
        end
      end

      S_PB_REL: begin
        rel_vld = 1'b1;
        b_raddr = cur_q.parent;
        state_d = S_PB_PL;
      end

      S_PB_PL: begin
        cur_d     = b_rd;
        cur_idx_d = cur_q.parent;
        state_d   = S_PB_CHK;
      end

      S_PB_FIN: begin
        b_we         = 1'b1;
        b_wdata      = cur_q;
        b_wdata.kind = K_FREE;
        sub_idx_d    = cur_idx_q;
        sub_ord_d    = cur_q.order;
        ret_d        = S_DONE;
        state_d      = S_PUSH0;
      end

      // append to the back of a free list
      S_PUSH0: begin
        l_we    = 1'b1;
        l_wdata = '{nxt: sub_idx_q, prv: ne_q[so] ? tail_q[so] : sub_idx_q};
        if (ne_q[so]) begin
          state_d = S_PUSH1;
        end else begin
          head_d[so] = sub_idx_q;
          tail_d[so] = sub_idx_q;
          ne_d[so]   = 1'b1;
          state_d    = ret_q;
        end
      end

      S_PUSH1: begin
        l_we       = 1'b1;
        l_waddr    = tail_q[so];
        l_wdata    = '{nxt: sub_idx_q, prv: '0};
        l_wmask    = '{nxt: '1, prv: '0};
        tail_d[so] = sub_idx_q;
        state_d    = ret_q;
      end

      // unlink from a free list
      S_RM0: begin
        state_d = S_RM1;
      end

      S_RM1: begin
        lk_d = l_rd;
        if ((head_q[so] == sub_idx_q) && (tail_q[so] == sub_idx_q)) begin
          ne_d[so] = 1'b0;
          state_d  = ret_q;
        end else if (head_q[so] == sub_idx_q) begin
          head_d[so] = l_rd.nxt;
          state_d    = ret_q;
        end else if (tail_q[so] == sub_idx_q) begin
          tail_d[so] = l_rd.prv;
          state_d    = ret_q;
        end else begin
          l_we    = 1'b1;
          l_waddr = l_rd.prv;
          l_wdata = '{nxt: l_rd.nxt, prv: '0};
          l_wmask = '{nxt: '1, prv: '0};
          state_d = S_RM2;
        end
      end

      S_RM2: begin
        l_we    = 1'b1;
        l_waddr = lk_q.nxt;
        l_wdata = '{nxt: '0, prv: lk_q.prv};
        l_wmask = '{nxt: '0, prv: '1};
        state_d = ret_q;
      end

      // descriptor take: group, then bit
      S_TK0: begin
        grp_latch = 1'b1;
        state_d   = S_TK1;
      end

      S_TK1: begin
        take    = 1'b1;
        tk_d    = take_idx;
        state_d = ret_q;
      end

      S_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      ne_q      <= '0;
      chk_vld_q <= 1'b0;
      scan_q    <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < NUM_ORDERS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      ne_q      <= ne_d;
      chk_vld_q <= chk_vld_d;
      scan_q    <= scan_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    pn_q      <= pn_d;
    sz_q      <= sz_d;
    pages_q   <= pages_d;
    bit_q     <= bit_d;
    ord_q     <= ord_d;
    src_q     <= src_d;
    cur_q     <= cur_d;
    cur_idx_q <= cur_idx_d;
    l_idx_q   <= l_idx_d;
    tk_q      <= tk_d;
    sub_idx_q <= sub_idx_d;
    sub_ord_q <= sub_ord_d;
    chk_idx_q <= chk_idx_d;
    lk_q      <= lk_d;
    st_q      <= st_d;
    rp_q      <= rp_d;
    ro_q      <= ro_d;
    if (out_load) begin
      out_st_q   <= st_q;
      out_page_q <= rp_q;
      out_ord_q  <= ro_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = OUT_W'({out_ord_q, out_page_q});

endmodule

### tb/tb_top.sv
// Self-checking testbench for buddy_page_allocator_unit: drives requests on the
// slave stream, predicts each result with its own allocator model, checks the master stream.
// Depends on bpa_pkg and the RTL top level.
module tb_top;
  import bpa_pkg::*;

  localparam int unsigned NORD  = NumOrdersDef;
  localparam int unsigned PGB   = PageBytesDef;
  localparam int unsigned NDESC = MaxBlocksDef;
  localparam int unsigned PNB   = PageNumberBitsDef;
  localparam int unsigned IN_W  = ((PNB + 32 + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((PNB + ORDER_W + 7) / 8) * 8;

  typedef struct {
    status_e        status;
    logic [PNB-1:0] page;
    logic [3:0]     order;
  } alloc_res_t;

  typedef struct {
    logic [PNB-1:0] page;
    int unsigned    order;
    kind_e          kind;
    pos_e           pos;
    int unsigned    buddy;
    int unsigned    parent;
  } desc_t;

  // Predicts allocator results and checks them in order
  class alloc_scoreboard;
    desc_t       blk[NDESC];
    int unsigned nxt[NDESC];
    int unsigned prv[NDESC];
    int unsigned head[NORD];
    int unsigned tail[NORD];
    bit          busy[NORD];
    bit          avail[NDESC];
    alloc_res_t  pending[$];
    int unsigned errors;

    function new();
      for (int i = 0; i < NDESC; i++) begin
        blk[i] = '{page: '0, order: 0, kind: K_UNUSED, pos: P_TOP, buddy: 0, parent: 0};
        nxt[i] = 0; prv[i] = 0; avail[i] = 1;
      end
      for (int o = 0; o < NORD; o++) begin
        head[o] = 0; tail[o] = 0; busy[o] = 0;
      end
      errors = 0;
    endfunction

    function void list_push(int unsigned i);
      int unsigned o;
      o = blk[i].order;
      if (busy[o]) begin
        nxt[tail[o]] = i; prv[i] = tail[o];
      end else begin
        head[o] = i; prv[i] = i;
      end
      nxt[i] = i; tail[o] = i; busy[o] = 1;
    endfunction

    function void list_unlink(int unsigned i);
      int unsigned o;
      bit h, t;
      o = blk[i].order;
      h = head[o] == i;
      t = tail[o] == i;
      if (h && t) busy[o] = 0;
      else if (h) head[o] = nxt[i];
      else if (t) tail[o] = prv[i];
      else begin
        nxt[prv[i]] = nxt[i];
        prv[nxt[i]] = prv[i];
      end
    endfunction

    function int unsigned free_descs();
      int unsigned n;
      n = 0;
      for (int i = 0; i < NDESC; i++) n += avail[i];
      return n;
    endfunction

    function int unsigned grab_desc();
      for (int i = 0; i < NDESC; i++)
        if (avail[i]) begin
          avail[i] = 0;
          return i;
        end
      return 0;
    endfunction

    // Release a block, merging upward while the sibling is free
    function void release_block(int unsigned i);
      int unsigned b, f;
      while (blk[i].pos != P_TOP) begin
        b = blk[i].buddy;
        f = blk[i].parent;
        if (blk[b].kind != K_FREE) break;
        list_unlink(b);
        blk[f].kind = K_ALLOC;
        avail[b] = 1; blk[b].kind = K_UNUSED;
        avail[i] = 1; blk[i].kind = K_UNUSED;
        i = f;
      end
      blk[i].kind = K_FREE;
      list_push(i);
    endfunction

    function void note_request(mode_e md, logic [PNB-1:0] pn, logic [31:0] sz);
      alloc_res_t r;
      logic [31:0] pages;
      int unsigned need, ord, src, d, f, l, rt;
      r = '{status: ST_OK, page: '0, order: '0};
      if (md == MODE_INSERT) begin
        pages = sz / PGB;
        if (pages == 0) r.status = ST_INVAL;
        else begin
          need = 0;
          for (int i = 0; i < NORD; i++) need += pages[i];
          if (need > free_descs()) r.status = ST_NOMEM;
          else
            for (int i = 0; i < NORD; i++)
              if (pages[i]) begin
                d = grab_desc();
                blk[d].page = pn; blk[d].order = i;
                blk[d].pos = P_TOP; blk[d].kind = K_ALLOC;
                release_block(d);
                pn = pn + (PNB'(1) << i);
              end
        end
      end else if (md == MODE_ALLOC) begin
        if (sz == 0) r.status = ST_INVAL;
        else begin
          pages = sz / PGB + ((sz % PGB) != 0);
          ord = NORD;
          for (int i = 0; i < NORD; i++)
            if (pages <= (32'd1 << i)) begin
              ord = i;
              break;
            end
          src = NORD;
          for (int j = ord; j < NORD; j++)
            if (busy[j]) begin
              src = j;
              break;
            end
          if (src >= NORD || 2 * (src - ord) > free_descs()) r.status = ST_NOMEM;
          else begin
            f = head[src];
            list_unlink(f);
            blk[f].kind = K_ALLOC;
            for (int k = src; k > ord; k--) begin
              l = grab_desc();
              rt = grab_desc();
              blk[l] = '{page: blk[f].page, order: k - 1, kind: K_ALLOC, pos: P_LEFT,
                         buddy: rt, parent: f};
              blk[rt] = '{page: blk[f].page + (PNB'(1) << (k - 1)), order: k - 1,
                          kind: K_ALLOC, pos: P_RIGHT, buddy: l, parent: f};
              blk[f].kind = K_SPLIT;
              release_block(rt);
              f = l;
            end
            r.page = blk[f].page;
            r.order = 4'(blk[f].order);
          end
        end
      end else begin
        d = NDESC;
        for (int i = 0; i < NDESC; i++)
          if (!avail[i] && blk[i].kind == K_ALLOC && blk[i].page == pn) begin
            d = i;
            break;
          end
        if (d >= NDESC) r.status = ST_NOTFOUND;
        else begin
          r.page = blk[d].page;
          r.order = 4'(blk[d].order);
          if (md == MODE_FREE) release_block(d);
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [PNB-1:0] pg, logic [3:0] od);
      alloc_res_t e;
      if (pending.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, st);
        errors++;
      end
      if (pg !== e.page) begin
        $error("result_page: expected %0h actual %0h", e.page, pg);
        errors++;
      end
      if (od !== e.order) begin
        $error("result_order: expected %0d actual %0d", e.order, od);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 0;
  logic             rst_ni = 0;
  logic             s_axis_tvalid = 0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;  // page_number, size_bytes, zero pad
  logic [1:0]       s_axis_tuser = '0;  // mode
  logic             m_axis_tvalid;
  logic             m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;       // result_page, result_order, zero pad
  logic [1:0]       m_axis_tuser;       // status

  alloc_scoreboard sb = new();
  bit              calm = 0;
  bit              sent_all = 0;
  logic [PNB-1:0]  handed[$];  // pages from successful results, used to aim frees and lookups

  buddy_page_allocator_unit u_dut (.*);

  initial forever #4 clk_i = ~clk_i;

  // Send one request and record it when the transfer happens; valid stays
  // up with the next request unless an idle burst follows
  task automatic send_req(mode_e md, logic [PNB-1:0] pn, logic [31:0] sz);
    int unsigned gap;
    bit rdy;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= md;
    s_axis_tdata  <= {{(IN_W - PNB - 32){1'b0}}, sz, pn};
    // ready only moves at rising edges, so the falling-edge value holds
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    sb.note_request(md, pn, sz);
  endtask

  task automatic send_random();
    int unsigned sel;
    logic [PNB-1:0] pn;
    sel = $urandom_range(0, 99);
    pn = PNB'($urandom_range(0, 255) << 6);
    if (sel < 8)
      send_req(MODE_INSERT, pn, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 2048) * PGB);
    else if (sel < 48)
      send_req(MODE_ALLOC, '0, $urandom_range(0, 9) == 0 ? $urandom() :
               $urandom_range(1, 1 << $urandom_range(0, 22)));
    else if (sel < 80 && handed.size() > 0) begin
      pn = handed[$urandom_range(0, handed.size() - 1)];
      send_req($urandom_range(0, 2) == 0 ? MODE_LOOKUP : MODE_FREE, pn, $urandom());
    end else
      send_req(sel[0] ? MODE_FREE : MODE_LOOKUP, PNB'($urandom()), $urandom());
  endtask

  // Result side: random stalls, checks each transfer
  initial begin
    int unsigned    stall;
    bit             seen;
    logic [1:0]     st;
    logic [PNB-1:0] pg;
    logic [3:0]     od;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 0;
        stall = $urandom_range(1, 11);
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      // output registers only move at rising edges
      @(negedge clk_i);
      seen = m_axis_tvalid;
      st   = m_axis_tuser;
      pg   = m_axis_tdata[PNB-1:0];
      od   = m_axis_tdata[PNB +: 4];
      @(posedge clk_i);
      if (seen) begin
        if (st == ST_OK) handed.push_back(pg);
        if (handed.size() > 64) void'(handed.pop_front());
        sb.check_result(st, pg, od);
      end
    end
  end

  // Stimulus
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: misses, invalid sizes, oversize, inserts, splits, merges
    send_req(MODE_LOOKUP, '0, '0);
    send_req(MODE_FREE, '1, '1);
    send_req(MODE_ALLOC, '0, '0);
    send_req(MODE_ALLOC, '0, 32'd1);
    send_req(MODE_INSERT, '0, PGB - 1);
    send_req(MODE_INSERT, '0, '1);
    send_req(MODE_INSERT, 20'hFFF00, 32'd3 * PGB);
    send_req(MODE_ALLOC, '0, 32'd1025 * PGB);
    send_req(MODE_ALLOC, '0, 32'd1024 * PGB);
    send_req(MODE_ALLOC, '0, 32'd1);
    send_req(MODE_ALLOC, '0, PGB + 1);
    send_req(MODE_ALLOC, '0, 32'd5 * PGB);
    send_req(MODE_LOOKUP, '0, '0);
    send_req(MODE_FREE, '0, '0);
    send_req(MODE_FREE, 20'h00001, '0);
    send_req(MODE_FREE, '0, '0);
    send_req(MODE_ALLOC, '0, '1);
    // Wait for every result before going random
    s_axis_tvalid <= 0;
    wait (sb.pending.size() == 0);
    for (int n = 0; n < 2000; n++) begin
      if (n == 1800) calm = 1;
      send_random();
    end
    s_axis_tvalid <= 0;
    sent_all = 1;
  end

  // End of run
  initial begin
    wait (sent_all);
    wait (sb.pending.size() == 0);
    repeat (600) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #40000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
